>>> sv/nkrs_pkg.sv
// Package for the nearest-K range selector: list size, slot and candidate records,
// configuration record and register indexes. Depends on nothing.
package nkrs_pkg;

	// Number of cells in the sorted list (1 to 64).
	localparam int LIST_SIZE = 16;
	// At most sixteen ranks are ever sent out.
	localparam int MAX_EMIT = 16;
	localparam int N_EMIT = (LIST_SIZE < MAX_EMIT) ? LIST_SIZE : MAX_EMIT;

	localparam int ID_W = 16;
	localparam int POS_W = 20;
	localparam int DELTA_W = POS_W + 1;
	localparam int SQ_W = 2 * DELTA_W - 1;
	localparam int DIST_W = 42;
	localparam int RANGE_W = 19;
	localparam int LIM_W = 2 * RANGE_W;
	localparam int IDX_W = 4;

	typedef struct packed {
		logic              occ;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_sq;
	} slot_t;

	typedef struct packed {
		logic              ins;
		logic              clr;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_sq;
	} cand_t;

	typedef struct packed {
		logic signed [POS_W-1:0] centre_x;
		logic signed [POS_W-1:0] centre_y;
		logic signed [POS_W-1:0] centre_z;
		logic [RANGE_W-1:0]      scan_range;
		logic                    skip_dead;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_CENTRE_X   = 3'd0,
		REG_CENTRE_Y   = 3'd1,
		REG_CENTRE_Z   = 3'd2,
		REG_SCAN_RANGE = 3'd3,
		REG_SKIP_DEAD  = 3'd4
	} reg_idx_t;

	localparam slot_t SLOT_EMPTY = '{occ: 1'b0, id: '0, dist_sq: '1};

endpackage

>>> sv/nkrs_dist.sv
// Three-stage squared-distance and range check for the nearest-K range selector.
// Depends on nkrs_pkg.
module nkrs_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [nkrs_pkg::ID_W-1:0]           entity_id,
	input  logic signed [nkrs_pkg::POS_W-1:0]   pos_x,
	input  logic signed [nkrs_pkg::POS_W-1:0]   pos_y,
	input  logic signed [nkrs_pkg::POS_W-1:0]   pos_z,
	input  logic                                is_dead,
	input  logic                                first_of_scan,
	input  logic                                last_of_scan,
	input  nkrs_pkg::cfg_t                      cfg,
	output nkrs_pkg::cand_t                     cand,
	output logic                                last_s3,
	output logic                                last_busy
);
	import nkrs_pkg::*;

	logic [LIM_W-1:0] lim_q;

	logic keep_s1, clr_s1, last_s1;
	logic [ID_W-1:0] id_s1;
	logic signed [DELTA_W-1:0] dx_s1, dy_s1, dz_s1;

	logic keep_s2, clr_s2, last_s2;
	logic [ID_W-1:0] id_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;

	logic signed [2*DELTA_W-1:0] px, py, pz;
	logic [DIST_W-1:0] sum;

	logic ins_s3, clr_s3;
	logic [ID_W-1:0] id_s3;
	logic [DIST_W-1:0] dsq_s3;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;
	assign sum = DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);

	// The squared limit only changes after a register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else begin
			lim_q <= LIM_W'(cfg.scan_range) * LIM_W'(cfg.scan_range);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_s1 <= 1'b0;
			clr_s1  <= 1'b0;
			last_s1 <= 1'b0;
			keep_s2 <= 1'b0;
			clr_s2  <= 1'b0;
			last_s2 <= 1'b0;
			ins_s3  <= 1'b0;
			clr_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			keep_s1 <= accept & ~(cfg.skip_dead & is_dead);
			clr_s1  <= accept & first_of_scan;
			last_s1 <= accept & last_of_scan;
			keep_s2 <= keep_s1;
			clr_s2  <= clr_s1;
			last_s2 <= last_s1;
			ins_s3  <= keep_s2 & (sum < DIST_W'(lim_q));
			clr_s3  <= clr_s2;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		id_s1 <= entity_id;
		dx_s1 <= $signed({pos_x[POS_W-1], pos_x})
			- $signed({cfg.centre_x[POS_W-1], cfg.centre_x});
		dy_s1 <= $signed({pos_y[POS_W-1], pos_y})
			- $signed({cfg.centre_y[POS_W-1], cfg.centre_y});
		dz_s1 <= $signed({pos_z[POS_W-1], pos_z})
			- $signed({cfg.centre_z[POS_W-1], cfg.centre_z});
		id_s2 <= id_s1;
		sqx_s2 <= px[SQ_W-1:0];
		sqy_s2 <= py[SQ_W-1:0];
		sqz_s2 <= pz[SQ_W-1:0];
		id_s3  <= id_s2;
		dsq_s3 <= sum;
	end

	assign cand = '{ins: ins_s3, clr: clr_s3, id: id_s3, dist_sq: dsq_s3};
	assign last_busy = last_s1 | last_s2 | last_s3;

endmodule

>>> sv/nkrs_cell.sv
// One rank of the sorted list: holds a slot and passes it to the next rank on insertion.
// Depends on nkrs_pkg.
module nkrs_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  nkrs_pkg::cand_t cand,
	input  nkrs_pkg::slot_t prev_eff,
	input  logic            prev_take,
	output nkrs_pkg::slot_t eff,
	output logic            take,
	output nkrs_pkg::slot_t slot
);
	import nkrs_pkg::*;

	slot_t slot_q;
	slot_t slot_d;
	slot_t cand_slot;

	// A clear empties the list before the candidate looks at it.
	assign eff = cand.clr ? SLOT_EMPTY : slot_q;
	// Insert before the first empty slot or the first strictly larger distance.
	assign take = cand.ins & (~eff.occ | (cand.dist_sq < eff.dist_sq));
	assign cand_slot = '{occ: 1'b1, id: cand.id, dist_sq: cand.dist_sq};

	always_comb begin
		if (prev_take) begin
			slot_d = prev_eff;
		end else if (take) begin
			slot_d = cand_slot;
		end else begin
			slot_d = eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_EMPTY;
		end else begin
			slot_q <= slot_d;
		end
	end

	assign slot = slot_q;

endmodule

>>> sv/nkrs_emit.sv
// Output shift buffer: takes a snapshot of the leading ranks and sends one per request.
// Depends on nkrs_pkg.
module nkrs_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  nkrs_pkg::slot_t                  src [nkrs_pkg::N_EMIT],
	input  logic                             res_stall,
	output logic                             res_valid,
	output logic [nkrs_pkg::IDX_W-1:0]       slot_index,
	output logic                             slot_valid,
	output logic [nkrs_pkg::ID_W-1:0]        found_id,
	output logic [nkrs_pkg::DIST_W-1:0]      found_distance_sq,
	output logic                             result_last
);
	import nkrs_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_EMIT - 1);

	slot_t hold_q [N_EMIT];
	logic valid_q;
	logic [IDX_W-1:0] idx_q;
	logic take_out;

	assign take_out = valid_q & ~res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take_out) begin
			if (idx_q == LAST_IDX) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_EMIT; k++) begin
			if (load) begin
				hold_q[k] <= src[k];
			end else if (take_out && k < N_EMIT - 1) begin
				hold_q[k] <= hold_q[(k + 1) % N_EMIT];
			end
		end
	end

	assign res_valid = valid_q;
	assign slot_index = idx_q;
	assign slot_valid = hold_q[0].occ;
	assign found_id = hold_q[0].occ ? hold_q[0].id : '0;
	assign found_distance_sq = hold_q[0].occ ? hold_q[0].dist_sq : '1;
	assign result_last = (idx_q == LAST_IDX);

endmodule

>>> sv/nearest_k_range_selector_core.sv
// Top level of the nearest-K range selector: register port, distance pipeline,
// chain of list cells and output buffer. Depends on nkrs_pkg, nkrs_dist, nkrs_cell, nkrs_emit.
//
// Usage: each request on the req channel carries one candidate (id, position, dead flag,
// first/last flags). Candidates that pass the dead and range checks are inserted into
// a row of LIST_SIZE cells kept sorted closest first; a candidate with first_of_scan
// clears the row before it is handled. A request with last_of_scan makes the block send
// the leading min(LIST_SIZE, 16) ranks on the res channel, one rank per request,
// rank 0 first, with result_last on the final one.
// Throughput: one candidate per cycle while no list is being sent. The distance
// pipeline is three stages deep (s1, s2, s3) and the cell row registers the candidate from s3;
// after last_of_scan, res_valid rises once last_s3 and then load_pending_q have passed it on.
// From that request until the last rank leaves, req_stall stays high; this covers the
// pipeline drain, the snapshot into the output buffer and the sending of every rank.
// A stall on res holds the current rank in place; the cell row is not disturbed.
// Reset clears the registers to zero, empties every cell and drops any pending output.
// Registers (APB, byte address 4*i): centre_x, centre_y, centre_z, scan_range, skip_dead.
// They are meant to be written only while the block is idle; pready is always high.
module nearest_k_range_selector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [4:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [nkrs_pkg::ID_W-1:0]          entity_id,
	input  logic signed [nkrs_pkg::POS_W-1:0]  pos_x,
	input  logic signed [nkrs_pkg::POS_W-1:0]  pos_y,
	input  logic signed [nkrs_pkg::POS_W-1:0]  pos_z,
	input  logic                               is_dead,
	input  logic                               first_of_scan,
	input  logic                               last_of_scan,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [nkrs_pkg::IDX_W-1:0]         slot_index,
	output logic                               slot_valid,
	output logic [nkrs_pkg::ID_W-1:0]          found_id,
	output logic [nkrs_pkg::DIST_W-1:0]        found_distance_sq,
	output logic                               result_last
);
	import nkrs_pkg::*;

	cfg_t cfg_q;
	logic cfg_wr;
	logic req_take;
	logic last_busy;
	logic last_s3;
	logic load_pending_q;
	cand_t cand;

	slot_t eff_w [LIST_SIZE];
	slot_t slot_w [LIST_SIZE];
	logic take_w [LIST_SIZE];
	slot_t emit_src [N_EMIT];
	logic [LIST_SIZE-1:0] occ_vec;

	// Register port. Writes complete in the access phase; reads return the
	// stored value, sign-extended for the centre coordinates.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_CENTRE_X:   cfg_q.centre_x <= pwdata[POS_W-1:0];
				REG_CENTRE_Y:   cfg_q.centre_y <= pwdata[POS_W-1:0];
				REG_CENTRE_Z:   cfg_q.centre_z <= pwdata[POS_W-1:0];
				REG_SCAN_RANGE: cfg_q.scan_range <= pwdata[RANGE_W-1:0];
				REG_SKIP_DEAD:  cfg_q.skip_dead <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CENTRE_X:   prdata = 32'(cfg_q.centre_x);
			REG_CENTRE_Y:   prdata = 32'(cfg_q.centre_y);
			REG_CENTRE_Z:   prdata = 32'(cfg_q.centre_z);
			REG_SCAN_RANGE: prdata = 32'(cfg_q.scan_range);
			REG_SKIP_DEAD:  prdata = 32'(cfg_q.skip_dead);
			default:        prdata = '0;
		endcase
	end

	// New requests wait while a list is on its way out, so the snapshot
	// always lands in an empty output buffer.
	assign req_stall = last_busy | load_pending_q | res_valid;
	assign req_take = req_valid & ~req_stall;

	nkrs_dist u_dist (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (req_take),
		.entity_id     (entity_id),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.is_dead       (is_dead),
		.first_of_scan (first_of_scan),
		.last_of_scan  (last_of_scan),
		.cfg           (cfg_q),
		.cand          (cand),
		.last_s3       (last_s3),
		.last_busy     (last_busy)
	);

	// The cell row: every cell sees the candidate, and each hands its contents
	// and its insert decision to the next rank down.
	for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
		if (i == 0) begin : g_head
			nkrs_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cand      (cand),
				.prev_eff  (SLOT_EMPTY),
				.prev_take (1'b0),
				.eff       (eff_w[i]),
				.take      (take_w[i]),
				.slot      (slot_w[i])
			);
		end else begin : g_body
			nkrs_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cand      (cand),
				.prev_eff  (eff_w[i-1]),
				.prev_take (take_w[i-1]),
				.eff       (eff_w[i]),
				.take      (take_w[i]),
				.slot      (slot_w[i])
			);
		end
		assign occ_vec[i] = slot_w[i].occ;
	end

	for (genvar k = 0; k < N_EMIT; k++) begin : g_src
		assign emit_src[k] = slot_w[k];
	end

	// The row takes the last candidate from s3 on the same edge that sets load_pending_q;
	// the snapshot is taken on the following edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pending_q <= 1'b0;
		end else begin
			load_pending_q <= last_s3;
		end
	end

	nkrs_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (load_pending_q),
		.src               (emit_src),
		.res_stall         (res_stall),
		.res_valid         (res_valid),
		.slot_index        (slot_index),
		.slot_valid        (slot_valid),
		.found_id          (found_id),
		.found_distance_sq (found_distance_sq),
		.result_last       (result_last)
	);

`ifndef SYNTHESIS
	a_no_req_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(req_valid && !req_stall))
		else $error("request taken while a list is being sent");

	a_snapshot_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load_pending_q |-> !res_valid)
		else $error("snapshot would overwrite a list still being sent");

	a_occupied_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec + LIST_SIZE'(1)) & occ_vec) == '0)
		else $error("occupied cells are not a leading run");
`endif

endmodule
